### hdl/slr_pkg.sv
// Shared types and constants of the spot light radiance core.
// Depends on nothing; every other file of the block imports it.
package slr_pkg;

   localparam int CoordW   = 21;   // Q10.10 coordinate
   localparam int DiffW    = 22;   // exact point minus light
   localparam int AxisW    = 16;   // Q1.14 axis component
   localparam int ColW     = 16;   // Q8.8 color
   localparam int SqW      = 43;   // one squared difference
   localparam int ApW      = 38;   // one axis product
   localparam int D2W      = 44;   // squared distance, Q24.20
   localparam int DotW     = 40;   // axis dot difference
   localparam int RootW    = 22;   // distance, Q12.10
   localparam int SqRemW   = 24;   // square root remainder
   localparam int DivRemW  = 45;   // divider partial remainder
   localparam int OutW     = 32;   // Q16.16 radiance
   localparam int NumStg   = 32;   // back stages, one quotient bit each
   localparam int SqStg    = 22;   // stages that also produce a root bit
   localparam int QDepth   = 4;
   localparam int QPtrW    = 2;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 63;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_LIGHT_POS   = 3'd0,
      CSR_LIGHT_AXIS  = 3'd1,
      CSR_MAX_DIST    = 3'd2,
      CSR_CONE_COS    = 3'd3,
      CSR_COLOR_RED   = 3'd4,
      CSR_COLOR_GREEN = 3'd5,
      CSR_COLOR_BLUE  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [62:0]                lamp_pos;
      logic [47:0]                light_axis;
      logic [21:0]                max_dist;
      logic signed [AxisW-1:0]    cone_cos;
      logic [2:0][ColW-1:0]       color;      // 0 red, 1 green, 2 blue
   } cfg_type;

   typedef struct packed {
      logic [D2W-1:0]             d2;
      logic signed [DotW-1:0]     dot;
      logic                       zero;
      logic                       far;
   } qent_type;

   typedef struct packed {
      logic                       valid;
      logic [D2W-1:0]             d2;
      logic signed [DotW-1:0]     dot;
      logic                       zero;
      logic                       far;
      logic [SqRemW-1:0]          sq_rem;
      logic [RootW-1:0]           sq_root;
      logic signed [DotW-1:0]     cone_prod;
      logic                       outside;
      logic [2:0][ColW-1:0]       color;
      logic [2:0][DivRemW-1:0]    div_rem;
      logic [2:0][OutW-1:0]       quo;
      logic [2:0]                 sat;
   } stage_type;

endpackage

### hdl/slr_front.sv
// Front part: takes items, forms the light vector, squared distance, axis dot
// and the range and zero-distance classification. Depends on slr_pkg.
module slr_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [20:0]           req_point_x,
   input  logic signed [20:0]           req_point_y,
   input  logic signed [20:0]           req_point_z,
   input  slr_pkg::cfg_type             cfg,
   input  logic                         q_full,
   output logic                         q_push,
   output slr_pkg::qent_type            q_data
);
   import slr_pkg::*;

   logic                          s1_valid_ff;
   logic [2:0][CoordW-1:0]        s1_pt_ff;
   logic                          s2_valid_ff;
   logic [2:0][SqW-1:0]           s2_sq_ff, s2_sq_in;
   logic [2:0][ApW-1:0]           s2_ap_ff, s2_ap_in;
   logic                          s3_valid_ff;
   qent_type                      s3_ff, s3_in;
   logic [D2W-1:0]                md2_ff;
   logic                          adv;

   assign adv       = !(s3_valid_ff && q_full);
   assign req_ready = adv;
   assign q_push    = s3_valid_ff && !q_full;
   assign q_data    = s3_ff;

   always_comb begin
      logic signed [DiffW-1:0] d;
      logic signed [DiffW-1:0] l;
      logic signed [AxisW-1:0] a;
      logic signed [D2W-1:0]   sqf;
      logic signed [ApW-1:0]   apf;
      for (int i = 0; i < 3; i++) begin
         l   = DiffW'($signed(cfg.lamp_pos[i*CoordW +: CoordW]));
         d   = DiffW'($signed(s1_pt_ff[i])) - l;
         a   = $signed(cfg.light_axis[i*AxisW +: AxisW]);
         sqf = d * d;
         apf = a * d;
         s2_sq_in[i] = sqf[SqW-1:0];
         s2_ap_in[i] = apf;
      end
   end

   always_comb begin
      s3_in.d2  = D2W'(s2_sq_ff[0]) + D2W'(s2_sq_ff[1]) + D2W'(s2_sq_ff[2]);
      s3_in.dot = DotW'($signed(s2_ap_ff[0])) + DotW'($signed(s2_ap_ff[1]))
                + DotW'($signed(s2_ap_ff[2]));
      s3_in.zero = (s3_in.d2 == '0);
      s3_in.far  = (s3_in.d2 > md2_ff);
   end

   always_ff @(posedge clock) begin
      md2_ff <= D2W'(cfg.max_dist) * D2W'(cfg.max_dist);
      if (adv) begin
         s1_pt_ff <= {req_point_z, req_point_y, req_point_x};
         s2_sq_ff <= s2_sq_in;
         s2_ap_ff <= s2_ap_in;
         s3_ff    <= s3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

endmodule

### hdl/slr_queue.sv
// Short queue between the front and back parts, kept in flip-flops.
// Depends on slr_pkg.
module slr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  slr_pkg::qent_type  push_data,
   input  logic               pop,
   output slr_pkg::qent_type  pop_data,
   output logic               empty,
   output logic               full
);
   import slr_pkg::*;

   qent_type             mem_ff [QDepth];
   logic [QPtrW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QPtrW:0]       cnt_ff;

   assign empty    = (cnt_ff == '0);
   assign full     = (cnt_ff == (QPtrW+1)'(QDepth));
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

### hdl/slr_back.sv
// Back part: a stage per quotient bit running three restoring dividers, a
// bit-pair square root and the cone test, then the result. Depends on slr_pkg.
module slr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  slr_pkg::cfg_type     cfg,
   input  logic                 q_empty,
   input  slr_pkg::qent_type    q_data,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_radiance_red,
   output logic [31:0]          rsp_radiance_green,
   output logic [31:0]          rsp_radiance_blue,
   output logic                 rsp_lit,
   output logic                 rsp_saturated
);
   import slr_pkg::*;

   function automatic stage_type stage_step(input stage_type s, input int k,
                                            input logic signed [AxisW-1:0] cc);
      stage_type               r;
      logic [1:0]              pair;
      logic [SqRemW-1:0]       rsh;
      logic [SqRemW-1:0]       trial;
      logic signed [DotW-1:0]  ce;
      logic signed [DotW-1:0]  re;
      logic signed [DotW:0]    ndot;
      logic signed [DotW:0]    pw;
      logic [OutW-1:0]         lowbits;
      logic [DivRemW-1:0]      dsh;
      r = s;
      // Square root, one result bit per stage from the top bit pair down.
      if (k < SqStg) begin
         pair  = s.d2[2*(SqStg-1-k) +: 2];
         rsh   = {s.sq_rem[SqRemW-3:0], pair};
         trial = {s.sq_root, 2'b01};
         if (rsh >= trial) begin
            r.sq_rem  = rsh - trial;
            r.sq_root = {s.sq_root[RootW-2:0], 1'b1};
         end else begin
            r.sq_rem  = rsh;
            r.sq_root = {s.sq_root[RootW-2:0], 1'b0};
         end
      end
      if (k == SqStg) begin
         ce = DotW'(cc);
         re = DotW'({1'b0, s.sq_root});
         r.cone_prod = ce * re;
      end
      if (k == SqStg + 1) begin
         ndot = (DotW+1)'(0) - {s.dot[DotW-1], s.dot};
         pw   = {s.cone_prod[DotW-1], s.cone_prod};
         r.outside = (ndot < pw);
      end
      // Dividend is color shifted up by 28; its low 32 bits enter one a stage.
      for (int c = 0; c < 3; c++) begin
         lowbits = {s.color[c][3:0], 28'd0};
         dsh = {s.div_rem[c][DivRemW-2:0], lowbits[OutW-1-k]};
         if (dsh >= {1'b0, s.d2}) begin
            r.div_rem[c] = dsh - {1'b0, s.d2};
            r.quo[c]     = {s.quo[c][OutW-2:0], 1'b1};
         end else begin
            r.div_rem[c] = dsh;
            r.quo[c]     = {s.quo[c][OutW-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   stage_type  head;
   stage_type  stg_ff [1:NumStg];
   stage_type  last;
   logic       adv;

   assign last      = stg_ff[NumStg];
   assign adv       = !last.valid || rsp_ready;
   assign q_pop     = adv && !q_empty;
   assign rsp_valid = last.valid;

   always_comb begin
      head           = '0;
      head.valid     = !q_empty;
      head.d2        = q_data.d2;
      head.dot       = q_data.dot;
      head.zero      = q_data.zero;
      head.far       = q_data.far;
      head.color     = cfg.color;
      for (int c = 0; c < 3; c++) begin
         // The upper dividend bits start the remainder; if they already reach
         // the divisor the quotient cannot fit in 32 bits.
         head.div_rem[c] = DivRemW'(cfg.color[c][ColW-1:4]);
         head.sat[c]     = (D2W'(cfg.color[c][ColW-1:4]) >= q_data.d2);
      end
   end

   genvar k;
   generate
      for (k = 0; k < NumStg; k++) begin : g_stg
         stage_type src;
         if (k == 0) begin : g_head
            assign src = head;
         end else begin : g_body
            assign src = stg_ff[k];
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               stg_ff[k+1].valid <= 1'b0;
            end else if (adv) begin
               stg_ff[k+1] <= stage_step(src, k, cfg.cone_cos);
            end
         end
      end
   endgenerate

   always_comb begin
      rsp_radiance_red   = '0;
      rsp_radiance_green = '0;
      rsp_radiance_blue  = '0;
      rsp_lit            = 1'b0;
      rsp_saturated      = 1'b0;
      if (last.zero) begin
         rsp_radiance_red   = '1;
         rsp_radiance_green = '1;
         rsp_radiance_blue  = '1;
         rsp_lit            = 1'b1;
         rsp_saturated      = 1'b1;
      end else if (!last.far && !last.outside) begin
         rsp_radiance_red   = last.sat[0] ? '1 : last.quo[0];
         rsp_radiance_green = last.sat[1] ? '1 : last.quo[1];
         rsp_radiance_blue  = last.sat[2] ? '1 : last.quo[2];
         rsp_lit            = 1'b1;
         rsp_saturated      = |last.sat;
      end
   end

endmodule

### hdl/spot_light_radiance_core.sv
// Top level of the spot light radiance core: configuration registers and the
// front part, queue and back part. Depends on slr_pkg, slr_front, slr_queue, slr_back.
//
//   Channel   Ports   Handshake            Carries
//   request   req_*   req_valid/req_ready  point x, y, z in signed Q10.10
//   response  rsp_*   rsp_valid/rsp_ready  three Q16.16 radiances, lit, saturated
//   config    csr_*   csr_wen              register index and write data
//
// One item is accepted every cycle while responses are taken; the rate is set by
// the back part, a chain of 32 stages that each produce one quotient bit of the
// three dividers. An item passes three front stages, the queue and 32 back stages.
// Reset is synchronous and clears the pipeline valid bits, the queue and the
// registers to their defaults. A stalled response holds the back part while
// the queue fills; the request side stalls only when the queue is full.
module spot_light_radiance_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [20:0]   req_point_x,
   input  logic signed [20:0]   req_point_y,
   input  logic signed [20:0]   req_point_z,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_radiance_red,
   output logic [31:0]          rsp_radiance_green,
   output logic [31:0]          rsp_radiance_blue,
   output logic                 rsp_lit,
   output logic                 rsp_saturated,
   input  logic                 csr_wen,
   input  logic [2:0]           csr_index,
   input  logic [62:0]          csr_wdata
);
   import slr_pkg::*;

   cfg_type    cfg_ff;
   logic       q_full, q_empty, q_push, q_pop;
   qent_type   q_in, q_out;

   // Configuration registers. Writes to the unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lamp_pos   <= '0;
         cfg_ff.light_axis <= '0;
         cfg_ff.max_dist   <= '1;
         cfg_ff.cone_cos   <= 16'sd16384;
         cfg_ff.color[0]   <= 16'd256;
         cfg_ff.color[1]   <= 16'd256;
         cfg_ff.color[2]   <= 16'd256;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_LIGHT_POS:   cfg_ff.lamp_pos   <= csr_wdata;
            CSR_LIGHT_AXIS:  cfg_ff.light_axis <= csr_wdata[47:0];
            CSR_MAX_DIST:    cfg_ff.max_dist   <= csr_wdata[21:0];
            CSR_CONE_COS:    cfg_ff.cone_cos   <= $signed(csr_wdata[15:0]);
            CSR_COLOR_RED:   cfg_ff.color[0]   <= csr_wdata[15:0];
            CSR_COLOR_GREEN: cfg_ff.color[1]   <= csr_wdata[15:0];
            CSR_COLOR_BLUE:  cfg_ff.color[2]   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   slr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .cfg         (cfg_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_in)
   );

   slr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty),
      .full      (q_full)
   );

   slr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_empty            (q_empty),
      .q_data             (q_out),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_radiance_red   (rsp_radiance_red),
      .rsp_radiance_green (rsp_radiance_green),
      .rsp_radiance_blue  (rsp_radiance_blue),
      .rsp_lit            (rsp_lit),
      .rsp_saturated      (rsp_saturated)
   );

endmodule
